// File: rtl/core/plap_pkg.sv
`default_nettype none
package plap_pkg;

  // Path storage
  localparam int MaxPoints = 256;
  localparam int PtAw      = $clog2(MaxPoints);
  localparam int CntW      = PtAw + 1;

  // Field widths
  localparam int CoordW = 32;
  localparam int DistW  = 31;
  localparam int SegW   = 8;

  // Projection parameter, Q0.16 with one spare bit for 1.0
  localparam int TW = 17;
  localparam logic [TW-1:0] TOne = 17'h10000;

  localparam logic [DistW-1:0] DistReset = 31'd32768;

  // Iteration counts of the serial units
  localparam int SqrtIters = 34;
  localparam int StepW     = DistW + 16;

  typedef enum logic [1:0] {
    REQ_START  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_QUERY  = 2'd2
  } req_e;

  // Magnitude of a 33-bit two's complement value
  function automatic logic [32:0] mag33(input logic [32:0] v);
    logic [32:0] r;
    r = v[32] ? (~v + 33'd1) : v;
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/plap_ram.sv
`default_nettype none
module plap_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// File: rtl/core/polyline_lookahead_point.sv
`default_nettype none
// Channel   Handshake                    Payload
// request   start / busy                 req_type_i, coord_x_i, coord_y_i
// result    result_valid_o (strobe)      target_x_o, target_y_o,
//                                        nearest_segment_o, overflow_seen_o
// config    cfg_valid_i / cfg_ready_o    cfg_data_i (lookahead distance)
//
// Start and append words are written to the point RAMs; an append to a full
// path is dropped and sets the overflow flag. A query on an empty path answers
// the next cycle, on a one-point path through S_ONE and S_ONE_OUT. Otherwise the
// scan visits each segment and either clamps the projection or divides (shared
// multiplier, normalize shift, 16-step divider). The walk then runs the 34-step
// square root per segment visited and ends with the 47-step divider. Reset
// clears the path; no clearing pass. Results cannot be stalled: each is shown
// for one cycle.
module polyline_lookahead_point (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          req_type_i,
  input  logic signed [plap_pkg::CoordW-1:0]  coord_x_i,
  input  logic signed [plap_pkg::CoordW-1:0]  coord_y_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [plap_pkg::DistW-1:0]          cfg_data_i,
  output logic                                result_valid_o,
  output logic signed [plap_pkg::CoordW-1:0]  target_x_o,
  output logic signed [plap_pkg::CoordW-1:0]  target_y_o,
  output logic [plap_pkg::SegW-1:0]           nearest_segment_o,
  output logic                                overflow_seen_o
);
  import plap_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_ONE, S_ONE_OUT, S_RD0, S_LOAD_A, S_LOAD_B, S_SQ1, S_SQ2,
    S_DOT1, S_DOT2, S_PROJ, S_NORM, S_DIV, S_LERPX, S_LERPY, S_LERPD,
    S_D1, S_D2, S_CMP, S_NEXT, S_SQRT, S_AVAIL, S_AVAIL2, S_SDIV, S_TT
  } state_e;

  // Control state
  state_e           state_q;
  logic [CntW-1:0]  count_q;
  logic             ovf_q;
  logic [DistW-1:0] dist_q;
  logic [PtAw-1:0]  seg_q;
  logic             walk_q;
  logic [5:0]       cnt_q;

  // Datapath registers
  logic [31:0]  px_q, py_q, ax_q, ay_q, bx_q, by_q, ox_q, oy_q;
  logic [32:0]  dx_q, dy_q, ex_q, ey_q;
  logic [67:0]  prod_q;
  logic [66:0]  len2_q, pos_q, neg_q, m_q, d2_q, best_d2_q;
  logic [TW-1:0] t_q, best_t_q;
  logic [PtAw-1:0] best_seg_q;
  logic [DistW-1:0] remain_q;
  logic [33:0]  len_q;
  logic [67:0]  sq_in_q;
  logic [36:0]  sq_rem_q;
  logic [StepW-1:0] num_q, qacc_q;
  logic [34:0]  drem_q;

  // RAM ports
  logic            ram_we;
  logic [PtAw-1:0] ram_waddr, ram_raddr;
  logic [31:0]     ram_x, ram_y;

  logic accept;
  assign accept      = start && !busy;
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  // Store path points on start and append words
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count_q[PtAw-1:0];
    if (accept) begin
      case (req_type_i)
        REQ_START: begin
          ram_we    = 1'b1;
          ram_waddr = '0;
        end
        REQ_APPEND: ram_we = (count_q < CntW'(MaxPoints));
        default: ram_we = 1'b0;
      endcase
    end
  end

  // Read address follows the segment walk
  always_comb begin
    case (state_q)
      S_LOAD_A: ram_raddr = seg_q + PtAw'(1);
      S_NEXT:   ram_raddr = seg_q + PtAw'(2);
      default:  ram_raddr = seg_q;
    endcase
  end

  plap_ram #(.Width(CoordW), .Depth(MaxPoints)) u_ram_x (
    .clk_i(clk_i), .we_i(ram_we), .waddr_i(ram_waddr), .wdata_i(coord_x_i),
    .raddr_i(ram_raddr), .rdata_o(ram_x)
  );

  plap_ram #(.Width(CoordW), .Depth(MaxPoints)) u_ram_y (
    .clk_i(clk_i), .we_i(ram_we), .waddr_i(ram_waddr), .wdata_i(coord_y_i),
    .raddr_i(ram_raddr), .rdata_o(ram_y)
  );

  // Shared multiplier operands
  logic [33:0] mul_a, mul_b;
  logic [32:0] ddx, ddy;
  assign ddx = {px_q[31], px_q} - {ox_q[31], ox_q};
  assign ddy = {py_q[31], py_q} - {oy_q[31], oy_q};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_SQ1:   begin mul_a = {1'b0, mag33(dx_q)}; mul_b = {1'b0, mag33(dx_q)}; end
      S_SQ2:   begin mul_a = {1'b0, mag33(dy_q)}; mul_b = {1'b0, mag33(dy_q)}; end
      S_DOT1:  begin mul_a = {1'b0, mag33(ex_q)}; mul_b = {1'b0, mag33(dx_q)}; end
      S_DOT2:  begin mul_a = {1'b0, mag33(ey_q)}; mul_b = {1'b0, mag33(dy_q)}; end
      S_LERPX: begin mul_a = 34'(t_q); mul_b = {1'b0, mag33(dx_q)}; end
      S_LERPY: begin mul_a = 34'(t_q); mul_b = {1'b0, mag33(dy_q)}; end
      S_D1:    begin mul_a = {1'b0, mag33(ddx)}; mul_b = {1'b0, mag33(ddx)}; end
      S_D2:    begin mul_a = {1'b0, mag33(ddy)}; mul_b = {1'b0, mag33(ddy)}; end
      S_AVAIL: begin mul_a = len_q; mul_b = 34'(TOne - t_q); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Projection decision
  logic [66:0] pos_sum, neg_sum, m_diff, len2_sum, d2_sum;
  logic        s2, proj_zero, proj_one;
  assign s2       = ey_q[32] ^ dy_q[32];
  assign pos_sum  = pos_q + (s2 ? 67'd0 : prod_q[66:0]);
  assign neg_sum  = neg_q + (s2 ? prod_q[66:0] : 67'd0);
  assign m_diff   = pos_sum - neg_sum;
  assign proj_zero = (len2_q == '0) || (pos_sum <= neg_sum);
  assign proj_one  = (m_diff >= len2_q);
  assign len2_sum = len2_q + prod_q[66:0];
  assign d2_sum   = d2_q + prod_q[66:0];

  // Point on segment: a + trunc(t * d / 2^16)
  logic [32:0] lmag;
  logic [33:0] loff, lsum;
  logic [31:0] lbase;
  logic        lneg;
  always_comb begin
    lmag  = prod_q[48:16];
    lneg  = (state_q == S_LERPY) ? dx_q[32] : dy_q[32];
    lbase = (state_q == S_LERPY) ? ax_q : ay_q;
    loff  = lneg ? (~{1'b0, lmag} + 34'd1) : {1'b0, lmag};
    lsum  = {{2{lbase[31]}}, lbase} + loff;
  end

  // Nearest segment bookkeeping
  logic            better;
  logic [PtAw-1:0] new_best;
  logic [TW-1:0]   new_t;
  assign better   = (seg_q == '0) || (d2_sum < best_d2_q);
  assign new_best = better ? seg_q : best_seg_q;
  assign new_t    = better ? t_q : best_t_q;

  logic [CntW-1:0] seg_p2;
  logic            more_segs, last_seg;
  assign seg_p2    = CntW'(seg_q) + CntW'(2);
  assign more_segs = (seg_p2 < count_q);
  assign last_seg  = (seg_p2 == count_q);

  // Walk step and serial units
  logic [34:0] avail;
  logic        take;
  assign avail = prod_q[50:16];
  assign take  = (avail >= 35'(remain_q)) || last_seg;

  logic [36:0] sq_next, sq_trial;
  logic        sq_ge;
  assign sq_next  = {sq_rem_q[34:0], sq_in_q[67:66]};
  assign sq_trial = {1'b0, len_q, 2'b01};
  assign sq_ge    = (sq_next >= sq_trial);

  logic [66:0] dv_next;
  logic        dv_ge;
  assign dv_next = {m_q[65:0], 1'b0};
  assign dv_ge   = (dv_next >= len2_q);

  logic [33:0] den;
  logic [34:0] sd_next;
  logic        sd_ge;
  assign den     = (len_q == '0) ? 34'd1 : len_q;
  assign sd_next = {drem_q[33:0], num_q[StepW-1]};
  assign sd_ge   = (sd_next >= {1'b0, den});

  logic [StepW:0] tt_sum;
  assign tt_sum = (StepW+1)'(t_q) + {1'b0, qacc_q};

  // Sequencer, path bookkeeping and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= S_IDLE;
      count_q           <= '0;
      ovf_q             <= 1'b0;
      dist_q            <= DistReset;
      seg_q             <= '0;
      walk_q            <= 1'b0;
      cnt_q             <= '0;
      result_valid_o    <= 1'b0;
      target_x_o        <= '0;
      target_y_o        <= '0;
      nearest_segment_o <= '0;
      overflow_seen_o   <= 1'b0;
    end else begin
      result_valid_o <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        dist_q <= cfg_data_i;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            case (req_type_i)
              REQ_START: begin
                count_q <= CntW'(1);
                ovf_q   <= 1'b0;
              end
              REQ_APPEND: begin
                if (count_q < CntW'(MaxPoints)) begin
                  count_q <= count_q + CntW'(1);
                end else begin
                  ovf_q <= 1'b1;
                end
              end
              REQ_QUERY: begin
                seg_q  <= '0;
                walk_q <= 1'b0;
                if (count_q == '0) begin
                  result_valid_o    <= 1'b1;
                  target_x_o        <= coord_x_i;
                  target_y_o        <= coord_y_i;
                  nearest_segment_o <= '0;
                  overflow_seen_o   <= ovf_q;
                end else if (count_q == CntW'(1)) begin
                  state_q <= S_ONE;
                end else begin
                  state_q <= S_RD0;
                end
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_ONE:     state_q <= S_ONE_OUT;
        S_ONE_OUT: begin
          result_valid_o    <= 1'b1;
          target_x_o        <= ram_x;
          target_y_o        <= ram_y;
          nearest_segment_o <= '0;
          overflow_seen_o   <= ovf_q;
          state_q           <= S_IDLE;
        end
        S_RD0:    state_q <= S_LOAD_A;
        S_LOAD_A: state_q <= S_LOAD_B;
        S_LOAD_B: state_q <= S_SQ1;
        S_SQ1:    state_q <= S_SQ2;
        S_SQ2:    state_q <= S_DOT1;
        S_DOT1: begin
          if (walk_q) begin
            cnt_q   <= 6'(SqrtIters - 1);
            state_q <= S_SQRT;
          end else begin
            state_q <= S_DOT2;
          end
        end
        S_DOT2: state_q <= S_PROJ;
        S_PROJ: begin
          if (proj_zero || proj_one) begin
            state_q <= S_LERPX;
          end else begin
            state_q <= S_NORM;
          end
        end
        S_NORM: begin
          if (len2_q[66:48] == '0) begin
            cnt_q   <= 6'd15;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          cnt_q <= cnt_q - 6'd1;
          if (cnt_q == '0) begin
            state_q <= S_LERPX;
          end
        end
        S_LERPX: state_q <= S_LERPY;
        S_LERPY: state_q <= S_LERPD;
        S_LERPD: begin
          if (walk_q) begin
            result_valid_o    <= 1'b1;
            target_x_o        <= ox_q;
            target_y_o        <= lsum[31:0];
            nearest_segment_o <= SegW'(best_seg_q);
            overflow_seen_o   <= ovf_q;
            state_q           <= S_IDLE;
          end else begin
            state_q <= S_D1;
          end
        end
        S_D1: state_q <= S_D2;
        S_D2: state_q <= S_CMP;
        S_CMP: begin
          if (more_segs) begin
            state_q <= S_NEXT;
          end else begin
            seg_q   <= new_best;
            walk_q  <= 1'b1;
            state_q <= S_RD0;
          end
        end
        S_NEXT: begin
          seg_q   <= seg_q + PtAw'(1);
          state_q <= S_LOAD_B;
        end
        S_SQRT: begin
          cnt_q <= cnt_q - 6'd1;
          if (cnt_q == '0) begin
            state_q <= S_AVAIL;
          end
        end
        S_AVAIL: state_q <= S_AVAIL2;
        S_AVAIL2: begin
          if (take) begin
            cnt_q   <= 6'(StepW - 1);
            state_q <= S_SDIV;
          end else begin
            state_q <= S_NEXT;
          end
        end
        S_SDIV: begin
          cnt_q <= cnt_q - 6'd1;
          if (cnt_q == '0) begin
            state_q <= S_TT;
          end
        end
        S_TT:    state_q <= S_LERPX;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Geometry datapath
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (state_q)
      S_IDLE: begin
        px_q <= coord_x_i;
        py_q <= coord_y_i;
      end
      S_LOAD_A: begin
        ax_q <= ram_x;
        ay_q <= ram_y;
      end
      S_LOAD_B: begin
        bx_q <= ram_x;
        by_q <= ram_y;
        dx_q <= {ram_x[31], ram_x} - {ax_q[31], ax_q};
        dy_q <= {ram_y[31], ram_y} - {ay_q[31], ay_q};
        ex_q <= {px_q[31], px_q} - {ax_q[31], ax_q};
        ey_q <= {py_q[31], py_q} - {ay_q[31], ay_q};
      end
      S_SQ2:  len2_q <= prod_q[66:0];
      S_DOT1: begin
        len2_q   <= len2_sum;
        sq_in_q  <= {1'b0, len2_sum};
        sq_rem_q <= '0;
        len_q    <= '0;
      end
      S_DOT2: begin
        pos_q <= (ex_q[32] ^ dx_q[32]) ? 67'd0 : prod_q[66:0];
        neg_q <= (ex_q[32] ^ dx_q[32]) ? prod_q[66:0] : 67'd0;
      end
      S_PROJ: begin
        m_q <= m_diff;
        if (proj_zero) begin
          t_q <= '0;
        end else if (proj_one) begin
          t_q <= TOne;
        end else begin
          t_q <= '0;
        end
      end
      S_NORM: begin
        if (len2_q[66:48] != '0) begin
          len2_q <= len2_q >> 1;
          m_q    <= m_q >> 1;
        end else if (m_q >= len2_q) begin
          // Truncation can leave m equal to len2: take the leading quotient bit
          m_q <= m_q - len2_q;
          t_q <= TW'(1);
        end
      end
      S_DIV: begin
        m_q <= dv_ge ? (dv_next - len2_q) : dv_next;
        t_q <= {t_q[TW-2:0], dv_ge};
      end
      S_LERPY: ox_q <= lsum[31:0];
      S_LERPD: oy_q <= lsum[31:0];
      S_D2:    d2_q <= prod_q[66:0];
      S_CMP: begin
        if (better) begin
          best_d2_q  <= d2_sum;
          best_seg_q <= seg_q;
          best_t_q   <= t_q;
        end
        t_q      <= new_t;
        remain_q <= dist_q;
      end
      S_NEXT: begin
        ax_q <= bx_q;
        ay_q <= by_q;
        if (walk_q) begin
          t_q <= '0;
        end
      end
      S_SQRT: begin
        sq_rem_q <= sq_ge ? (sq_next - sq_trial) : sq_next;
        len_q    <= {len_q[32:0], sq_ge};
        sq_in_q  <= {sq_in_q[65:0], 2'b00};
      end
      S_AVAIL2: begin
        if (take) begin
          num_q  <= {remain_q, 16'd0};
          qacc_q <= '0;
          drem_q <= '0;
        end else begin
          remain_q <= remain_q - avail[DistW-1:0];
        end
      end
      S_SDIV: begin
        drem_q <= sd_ge ? (sd_next - {1'b0, den}) : sd_next;
        qacc_q <= {qacc_q[StepW-2:0], sd_ge};
        num_q  <= {num_q[StepW-2:0], 1'b0};
      end
      S_TT: begin
        t_q <= (tt_sum > (StepW+1)'(TOne)) ? TOne : tt_sum[TW-1:0];
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire
